@@ design/lpbp_pkg.sv @@
// Shared types and codes for the pinned LRU buffer pool tag table.
`default_nettype none
package lpbp_pkg;

  // Operation codes on the request channel.
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_PIN    = 3'd1;
  localparam logic [2:0] OP_EVICT  = 3'd2;
  localparam logic [2:0] OP_STATUS = 3'd3;
  localparam logic [2:0] OP_FLUSH  = 3'd4;
  localparam logic [2:0] OP_DELETE = 3'd5;

  // Result codes on the response channel.
  localparam logic [2:0] CODE_HIT    = 3'd0;
  localparam logic [2:0] CODE_MISS   = 3'd1;
  localparam logic [2:0] CODE_REJECT = 3'd2;
  localparam logic [2:0] CODE_WB     = 3'd3;
  localparam logic [2:0] CODE_DONE   = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  file_id;
    logic [19:0] block_number;
  } req_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [3:0]  slot;
    logic        wb_valid;
    logic [7:0]  wb_file_id;
    logic [19:0] wb_block_number;
    logic        present;
    logic        pinned;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  file;
    logic [19:0] block;
  } tag_t;

  // Broadcast commands for the row of age cells.
  typedef struct packed {
    logic rm_en;
    logic push_en;
    logic rot_en;
    logic pin_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ design/lpbp_cell.sv @@
// One position of the age-ordered chain: holds a tag, its slot and its pin bit.
`default_nettype none
module lpbp_cell #(
  parameter int CAPACITY = 16,
  parameter int IDX = 0,
  parameter int PW = 4
) (
  input  wire logic               clk,
  input  wire lpbp_pkg::cell_ctl_t ctl,
  input  wire logic [PW-1:0]      pos,
  input  wire logic [PW-1:0]      push_pos,
  input  wire logic [PW-1:0]      top_pos,
  input  wire lpbp_pkg::tag_t     push_tag,
  input  wire logic [PW-1:0]      push_slot,
  input  wire logic               push_pin,
  input  wire lpbp_pkg::tag_t     up_tag,
  input  wire logic [PW-1:0]      up_slot,
  input  wire logic               up_pin,
  input  wire lpbp_pkg::tag_t     head_tag,
  input  wire logic [PW-1:0]      head_slot,
  input  wire logic               head_pin,
  output lpbp_pkg::tag_t          tag,
  output logic [PW-1:0]           slot,
  output logic                    pin
);
  import lpbp_pkg::*;

  localparam logic [PW-1:0] POS = PW'(IDX);
  localparam int unsigned DEPTH = CAPACITY;

  // A push wins, then a shift down toward the old end, then a rotation, then a pin set.
  always_ff @(posedge clk) begin
    if (ctl.push_en && POS == push_pos && IDX < DEPTH) begin
      tag  <= push_tag;
      slot <= push_slot;
      pin  <= push_pin;
    end else if (ctl.rm_en && POS >= pos) begin
      tag  <= up_tag;
      slot <= up_slot;
      pin  <= up_pin;
    end else if (ctl.rot_en) begin
      if (POS == top_pos) begin
        tag  <= head_tag;
        slot <= head_slot;
        pin  <= head_pin;
      end else if (POS < top_pos) begin
        tag  <= up_tag;
        slot <= up_slot;
        pin  <= up_pin;
      end
    end else if (ctl.pin_en && POS == pos) begin
      pin <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ design/lru_pinned_buffer_pool_tags_top.sv @@
// Top level of the pinned LRU buffer pool tag table.
// Usage: requests arrive on req (req_valid/req_stall) carrying op, file_id and
// block_number; results leave on rsp (rsp_valid/rsp_stall), one beat per
// result, with last set on the final beat of each request.
// The tags live in a chain of cells kept in age order, oldest at cell 0.
// Read, pin, evict and status are looked up in state S_LOOK, which loads
// their result into the output register; the next request is accepted
// once the block is back in S_IDLE. A read miss that evicts gives two
// beats, the write-back and then the miss. Flush gives one beat per stored
// entry, one per cycle while the receiver does not stall, plus the closing
// beat. Delete-file rotates the chain once per deleted entry, and once more
// to find none left, watching for the smallest block number of the file.
// One request is in work at a time; req_stall is high until its last beat
// has been loaded into the output register.
// Reset empties the table. While the receiver stalls, the output beat holds
// and the block waits before producing the next one.
`default_nettype none
module lru_pinned_buffer_pool_tags_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire lpbp_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output lpbp_pkg::rsp_t      rsp
);
  import lpbp_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_MISS2 = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DEL   = 3'd5;

  logic [2:0]          state, state_next;
  logic [2:0]          op_r;
  tag_t                tag_r;
  logic [CW-1:0]       count, count_next;
  logic [CAPACITY-1:0] svalid, sv_set, sv_clr;
  logic [PW-1:0]       vslot, vslot_next;
  logic [CW-1:0]       scan, scan_next;
  logic                found, found_next;
  logic [19:0]         best_blk, best_blk_next;
  logic [PW-1:0]       best_slot, best_slot_next;

  tag_t                c_tag  [CAPACITY];
  logic [PW-1:0]       c_slot [CAPACITY];
  logic [CAPACITY-1:0] c_pin;

  cell_ctl_t           ctl;
  logic [PW-1:0]       pos, push_pos, top_pos, push_slot;
  logic                push_pin;
  tag_t                push_tag;

  logic                emit;
  rsp_t                beat;
  logic                can_emit;

  // Chain of cells, each fed by its younger neighbor and by the head.
  for (genvar q = 0; q < CAPACITY; q++) begin : g_cell
    localparam int UP = (q + 1 < CAPACITY) ? q + 1 : q;
    lpbp_cell #(.CAPACITY(CAPACITY), .IDX(q), .PW(PW)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (pos),
      .push_pos  (push_pos),
      .top_pos   (top_pos),
      .push_tag  (push_tag),
      .push_slot (push_slot),
      .push_pin  (push_pin),
      .up_tag    (c_tag[UP]),
      .up_slot   (c_slot[UP]),
      .up_pin    (c_pin[UP]),
      .head_tag  (c_tag[0]),
      .head_slot (c_slot[0]),
      .head_pin  (c_pin[0]),
      .tag       (c_tag[q]),
      .slot      (c_slot[q]),
      .pin       (c_pin[q])
    );
  end

  // Parallel compares along the chain and the small searches over them.
  logic                hit, hpin, vic, free_ok, dfound;
  logic [PW-1:0]       hpos, hslot, vpos, vsl, fs, dpos;

  always_comb begin
    hit = 1'b0; hpin = 1'b0; hpos = '0; hslot = '0;
    vic = 1'b0; vpos = '0; vsl = '0;
    free_ok = 1'b0; fs = '0;
    dfound = 1'b0; dpos = '0;
    for (int q = 0; q < CAPACITY; q++) begin
      if (CW'(q) < count) begin
        if (!hit && c_tag[q] == tag_r) begin
          hit = 1'b1; hpos = PW'(q); hslot = c_slot[q]; hpin = c_pin[q];
        end
        if (!vic && !c_pin[q]) begin
          vic = 1'b1; vpos = PW'(q); vsl = c_slot[q];
        end
        if (!dfound && c_slot[q] == best_slot) begin
          dfound = 1'b1; dpos = PW'(q);
        end
      end
      if (!free_ok && !svalid[q]) begin
        free_ok = 1'b1; fs = PW'(q);
      end
    end
  end

  assign can_emit  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign top_pos   = PW'(count - CW'(1));

  // Sequencer: decides the chain command and the beat of each cycle.
  always_comb begin
    state_next = state; ctl = '0; pos = '0;
    push_tag = tag_r; push_slot = '0; push_pin = 1'b0;
    emit = 1'b0; beat = '0; sv_set = '0; sv_clr = '0;
    vslot_next = vslot; scan_next = scan; found_next = found;
    best_blk_next = best_blk; best_slot_next = best_slot;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (can_emit) begin
          emit = 1'b1;
          beat.last = 1'b1;
          beat.code = CODE_DONE;
          state_next = S_IDLE;
          case (op_r)
            OP_READ: begin
              if (hit) begin
                beat.code = CODE_HIT; beat.slot = 4'(hslot); beat.present = 1'b1;
                ctl.rm_en = 1'b1; pos = hpos;
                ctl.push_en = 1'b1; push_slot = hslot; push_pin = hpin;
              end else if (count < CW'(CAPACITY) && free_ok) begin
                beat.code = CODE_MISS; beat.slot = 4'(fs);
                ctl.push_en = 1'b1; push_slot = fs;
                sv_set[fs] = 1'b1;
              end else if (!vic) begin
                beat.code = CODE_REJECT;
              end else begin
                beat.code = CODE_WB; beat.wb_valid = 1'b1; beat.last = 1'b0;
                beat.wb_file_id = c_tag[vpos].file;
                beat.wb_block_number = c_tag[vpos].block;
                ctl.rm_en = 1'b1; pos = vpos;
                ctl.push_en = 1'b1; push_slot = vsl;
                vslot_next = vsl;
                state_next = S_MISS2;
              end
            end
            OP_PIN: begin
              beat.present = hit;
              ctl.pin_en = hit; pos = hpos;
            end
            OP_EVICT: begin
              if (hit) begin
                beat.code = CODE_WB; beat.wb_valid = 1'b1; beat.present = 1'b1;
                beat.wb_file_id = tag_r.file; beat.wb_block_number = tag_r.block;
                ctl.rm_en = 1'b1; pos = hpos;
                sv_clr[hslot] = 1'b1;
              end
            end
            OP_STATUS: begin
              beat.present = hit; beat.pinned = hit && hpin;
            end
            OP_FLUSH: begin
              emit = 1'b0; state_next = S_FLUSH;
            end
            OP_DELETE: begin
              emit = 1'b0; scan_next = '0; found_next = 1'b0; state_next = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_MISS2: begin
        if (can_emit) begin
          emit = 1'b1; beat.code = CODE_MISS; beat.slot = 4'(vslot); beat.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          emit = 1'b1;
          if (count != '0) begin
            beat.code = CODE_WB; beat.wb_valid = 1'b1;
            beat.wb_file_id = c_tag[0].file; beat.wb_block_number = c_tag[0].block;
            ctl.rm_en = 1'b1; pos = '0;
            sv_clr[c_slot[0]] = 1'b1;
          end else begin
            beat.code = CODE_DONE; beat.last = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        // Rotate the chain once, watching the head for the smallest block of the file.
        if (scan != count) begin
          ctl.rot_en = 1'b1;
          scan_next = scan + CW'(1);
          if (c_tag[0].file == tag_r.file && (!found || c_tag[0].block < best_blk)) begin
            found_next = 1'b1; best_blk_next = c_tag[0].block; best_slot_next = c_slot[0];
          end
        end else if (found) begin
          state_next = S_DEL;
        end else if (can_emit) begin
          emit = 1'b1; beat.code = CODE_DONE; beat.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DEL: begin
        if (can_emit) begin
          emit = 1'b1; beat.code = CODE_WB; beat.wb_valid = 1'b1;
          beat.wb_file_id = tag_r.file; beat.wb_block_number = best_blk;
          ctl.rm_en = dfound; pos = dpos;
          sv_clr[best_slot] = 1'b1;
          scan_next = '0; found_next = 1'b0;
          state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
    push_pos   = PW'(count - CW'(ctl.rm_en));
    count_next = count + CW'(ctl.push_en) - CW'(ctl.rm_en);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      svalid <= '0;
      found <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      svalid <= (svalid | sv_set) & ~sv_clr;
      found <= found_next;
      if (emit) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op_r <= req.op;
      tag_r <= '{file: req.file_id, block: req.block_number};
    end
    if (emit) rsp <= beat;
    vslot <= vslot_next;
    scan <= scan_next;
    best_blk <= best_blk_next;
    best_slot <= best_slot_next;
  end

  // Checks on the table bookkeeping and the sequencer.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("entry count above capacity");
  a_slot_map: assert property (@(posedge clk) disable iff (rst)
    $countones(svalid) == int'(count)) else $error("slot map disagrees with count");
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_LOOK) else $error("request not looked up");

endmodule
`default_nettype wire
